FILE: rtl/lru_key_value_cache_macros.svh
// Assertion macros used by the checker of the LRU key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define LKVC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define LKVC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lkvc_pkg.sv
// Shared types and constants of the LRU key-value cache.
package lkvc_pkg;

  localparam int DEFAULT_ENTRIES = 64;
  localparam int KEY_BITS        = 16;
  localparam int VALUE_BITS      = 32;
  localparam int CAP_BITS        = 7;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

  // Request type codes.
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
    logic load_rsp;
  } ctl_cmd_t;

  typedef struct packed {
    logic rsp_free;
  } ctl_sts_t;

endpackage

FILE: rtl/lkvc_ctrl.sv
// Sequencing state machine of the LRU key-value cache.
module lkvc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  lkvc_pkg::ctl_sts_t sts,
  output lkvc_pkg::ctl_cmd_t cmd
);

  lkvc_pkg::ctl_state_t state;
  lkvc_pkg::ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkvc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lkvc_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = lkvc_pkg::ST_LOOKUP;
        end
      end
      lkvc_pkg::ST_LOOKUP: begin
        state_next = lkvc_pkg::ST_UPDATE;
      end
      lkvc_pkg::ST_UPDATE: begin
        state_next = lkvc_pkg::ST_FINISH;
      end
      lkvc_pkg::ST_FINISH: begin
        if (sts.rsp_free) begin
          state_next = lkvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      lkvc_pkg::ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      lkvc_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      lkvc_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      lkvc_pkg::ST_FINISH: begin
        cmd.load_rsp = sts.rsp_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/lkvc_datapath.sv
// Entry store, parallel key match, recency ranks and result register.
module lkvc_datapath #(
  parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lkvc_pkg::req_t                  req,
  input  logic                            cfg_valid,
  input  logic [lkvc_pkg::CAP_BITS-1:0]   cfg_capacity,
  input  logic                            rsp_ready,
  output logic                            rsp_valid,
  output lkvc_pkg::rsp_t                  rsp,
  input  lkvc_pkg::ctl_cmd_t              cmd,
  output lkvc_pkg::ctl_sts_t              sts
);

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int COUNT_W = $clog2(ENTRIES + 1);
  localparam int EW      = (COUNT_W > lkvc_pkg::CAP_BITS) ? COUNT_W : lkvc_pkg::CAP_BITS;

  logic [lkvc_pkg::CAP_BITS-1:0]   capacity;
  lkvc_pkg::req_t                  req_q;

  logic [ENTRIES-1:0]              entry_valid;
  logic [lkvc_pkg::KEY_BITS-1:0]   entry_key [ENTRIES];
  logic [IDX_W-1:0]                entry_rank [ENTRIES];
  logic [COUNT_W-1:0]              occupied;
  logic [lkvc_pkg::VALUE_BITS-1:0] value_mem [ENTRIES];
  logic [lkvc_pkg::VALUE_BITS-1:0] rd_data;

  logic                            hit_q;
  logic                            full_q;
  logic [IDX_W-1:0]                slot_q;
  logic [IDX_W-1:0]                hit_rank_q;

  logic [ENTRIES-1:0]              match;
  logic [ENTRIES-1:0]              lru;
  logic [IDX_W-1:0]                match_idx;
  logic [IDX_W-1:0]                hit_rank;
  logic [IDX_W-1:0]                lru_idx;
  logic [IDX_W-1:0]                free_idx;
  logic [IDX_W-1:0]                lru_rank;
  logic [EW-1:0]                   cap_ext;
  logic [EW-1:0]                   eff_cap;
  logic                            full;
  logic                            do_insert;

  // Capacity of zero acts as one; anything above the store size saturates.
  always_comb begin
    cap_ext = EW'(capacity);
    if (capacity == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(ENTRIES)) begin
      eff_cap = EW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    full = (EW'(occupied) >= eff_cap) && (occupied != '0);
  end

  // Ranks of valid entries always form 0 .. occupied-1, so the least recent
  // entry is the one whose rank equals occupied-1.
  assign lru_rank = IDX_W'(occupied - COUNT_W'(1));

  always_comb begin
    match_idx = '0;
    hit_rank  = '0;
    lru_idx   = '0;
    free_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_key[i] == req_q.key);
      lru[i]   = entry_valid[i] && (entry_rank[i] == lru_rank);
      if (match[i]) begin
        match_idx = match_idx | IDX_W'(i);
        hit_rank  = hit_rank | entry_rank[i];
      end
      if (lru[i]) begin
        lru_idx = lru_idx | IDX_W'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign do_insert = !hit_q && (req_q.req_type == lkvc_pkg::REQ_PUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.lookup) begin
      hit_q      <= |match;
      full_q     <= full;
      hit_rank_q <= hit_rank;
      if (|match) begin
        slot_q <= match_idx;
      end else if (full) begin
        slot_q <= lru_idx;
      end else begin
        slot_q <= free_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && do_insert) begin
      entry_key[slot_q] <= req_q.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupied    <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_rank[i] <= '0;
      end
    end else if (cmd.update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (entry_valid[i]) begin
          if (hit_q && (entry_rank[i] < hit_rank_q)) begin
            entry_rank[i] <= entry_rank[i] + IDX_W'(1);
          end else if (do_insert && (IDX_W'(i) != slot_q)) begin
            entry_rank[i] <= entry_rank[i] + IDX_W'(1);
          end
        end
      end
      if (hit_q || do_insert) begin
        entry_rank[slot_q] <= '0;
      end
      if (do_insert) begin
        entry_valid[slot_q] <= 1'b1;
        if (!full_q) begin
          occupied <= occupied + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (req_q.req_type == lkvc_pkg::REQ_PUT) begin
        value_mem[slot_q] <= req_q.value;
      end
      rd_data <= value_mem[slot_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rsp) begin
      rsp.hit <= hit_q;
      if (hit_q && (req_q.req_type == lkvc_pkg::REQ_GET)) begin
        rsp.read_value <= rd_data;
      end else begin
        rsp.read_value <= '0;
      end
    end
  end

  assign sts.rsp_free = !rsp_valid || rsp_ready;

endmodule

FILE: rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: controller plus datapath.
//
// Usage: requests arrive on the req channel (req_valid/req_ready), each item a
// get or a put with a key and, for a put, a value. Every request yields exactly
// one item on the rsp channel (rsp_valid/rsp_ready) carrying a hit flag and,
// for a get that hits, the stored value; all other results read zero.
// The capacity register is written through cfg_valid/cfg_capacity; cfg_ready
// is always high. Write it only while no request is in flight.
// Timing: an item accepted at one clock edge is matched against all keys in
// the next cycle, ranks and the value memory are updated in the cycle after,
// and the result is loaded into the output register at the end of the finish
// step, once that register is free. A new item is taken only after the last
// has passed the four sequencer steps: accept, lookup, update and finish.
// A new request is accepted while an earlier result still sits in the output
// register; if the receiver stalls longer, the sequencer holds the finished
// item until the output register frees up.
// Reset (synchronous, active high) empties the store, clears all ranks and
// sets capacity to 64. No clearing pass is needed.
module lru_key_value_cache #(
  parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  lkvc_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output lkvc_pkg::rsp_t                rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_capacity
);

  lkvc_pkg::ctl_cmd_t cmd;
  lkvc_pkg::ctl_sts_t sts;

  // The capacity register can be written in any cycle.
  assign cfg_ready = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lkvc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cfg_valid    (cfg_valid),
    .cfg_capacity (cfg_capacity),
    .rsp_ready    (rsp_ready),
    .rsp_valid    (rsp_valid),
    .rsp          (rsp),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

FILE: rtl/lkvc_checker.sv
// Port-level checker for the LRU key-value cache and its bind statement.
`include "lru_key_value_cache_macros.svh"

module lkvc_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input lkvc_pkg::rsp_t rsp
);

  // Requests accepted whose result has not yet been taken.
  logic [1:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      case ({req_valid && req_ready, rsp_valid && rsp_ready})
        2'b10: begin
          outstanding <= outstanding + 2'd1;
        end
        2'b01: begin
          outstanding <= outstanding - 2'd1;
        end
        default: begin
          outstanding <= outstanding;
        end
      endcase
    end
  end

  `LKVC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp item changed while stalled")
  `LKVC_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp.hit, rsp.read_value == '0, "miss result carries a nonzero value")
  `LKVC_ASSERT_NOW(a_no_phantom, rsp_valid, outstanding != 2'd0, "result offered with no request pending")
  `LKVC_ASSERT_ALWAYS(a_depth, outstanding != 2'd3, "more than two requests in flight")

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
